FILE: rtl/assert_macros.svh
// Assertion macros used by lzw_string_table.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define LZW_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define LZW_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LZW_ASSERT_IMP(label, ck, rn, ante, cons)
`define LZW_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/lzw_pkg.sv
// Shared constants, codes and types for the LZW string table.
// No dependencies; used by lzw_string_table.
package lzw_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_LEN     = 64;

    localparam int CODE_W = $clog2(TABLE_DEPTH);     // entry index
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1); // entry count / limit
    localparam int PRE_W  = CODE_W + 1;              // link plus has-link bit
    localparam int LEN_W  = $clog2(MAX_LEN + 1);     // string length
    localparam int SP_W   = $clog2(MAX_LEN);         // stack index
    localparam int BYTE_W = 8;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CODE_LIMIT_RESET = CNT_W'(TABLE_DEPTH);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ROOT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXTEND = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNUSED = 2'd2;
    localparam logic [STAT_W-1:0] ST_LONG   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_LONG,
        S_SETUP,
        S_EMIT
    } state_t;

endpackage

FILE: rtl/lzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lzw_string_table.sv
// LZW decoder dictionary: 4096 entries of suffix byte plus prefix link.
//
// Input channel (in_valid / in_stall): func, code, value. The block takes
// one item, then stalls the input until that item is done.
// Output channel (out_valid / out_stall): assigned_code, out_byte, last,
// status; one output register sits between the sequencer and the receiver.
// Config: cfg_write_en / cfg_write_data write code_limit (reset 4096); the
// user must write it only while the block is idle, the block does not enforce it.
// Per operation: clear, new root, extend, set suffix and errors each give
// one result; an undefined func gives no result.
// A read of an L-byte string: the prefix chain is walked one link per cycle
// through the table RAM read port, bytes are pushed on a stack RAM, then
// popped one per cycle to the output register while the output is not stalled.
// A string longer than 64 bytes ends the walk with status 3 and no bytes.
// A stalled output register holds its item; the sequencer waits for it.
// Reset clears the entry count and the control state and sets the limit to
// 4096; the RAMs are not cleared, entries are only read below the entry count.
// Depends on lzw_pkg, lzw_ram, assert_macros.svh.
`include "assert_macros.svh"

module lzw_string_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [lzw_pkg::CNT_W-1:0]     cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lzw_pkg::FUNC_W-1:0]    func,
    input  logic [lzw_pkg::CODE_W-1:0]    code,
    input  logic [lzw_pkg::BYTE_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lzw_pkg::CODE_W-1:0]    assigned_code,
    output logic [lzw_pkg::BYTE_W-1:0]    out_byte,
    output logic                          last,
    output logic [lzw_pkg::STAT_W-1:0]    status
);

    lzw_pkg::state_t state_reg, state_next;

    logic [lzw_pkg::FUNC_W-1:0] func_reg;
    logic [lzw_pkg::CODE_W-1:0] code_reg;
    logic [lzw_pkg::BYTE_W-1:0] value_reg;

    logic [lzw_pkg::CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [lzw_pkg::CNT_W-1:0]  code_limit_reg;
    logic [lzw_pkg::CODE_W-1:0] cur_reg, cur_next;
    logic [lzw_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [lzw_pkg::SP_W-1:0]   pos_reg, pos_next;

    logic                       out_valid_reg, out_valid_next;
    logic [lzw_pkg::CODE_W-1:0] out_assigned_reg, out_assigned_next;
    logic [lzw_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;
    logic [lzw_pkg::STAT_W-1:0] out_status_reg, out_status_next;

    // RAM ports
    logic                       suf_we;
    logic [lzw_pkg::CODE_W-1:0] suf_waddr;
    logic [lzw_pkg::BYTE_W-1:0] suf_wdata, suf_rdata;
    logic                       pre_we;
    logic [lzw_pkg::PRE_W-1:0]  pre_wdata, pre_rdata;
    logic                       stk_we;
    logic [lzw_pkg::BYTE_W-1:0] stk_rdata;

    // result being produced this cycle
    logic                       emit;
    logic [lzw_pkg::CODE_W-1:0] e_assigned;
    logic [lzw_pkg::BYTE_W-1:0] e_byte;
    logic                       e_last;
    logic [lzw_pkg::STAT_W-1:0] e_status;

    logic                      slot_free;
    logic                      used;
    logic                      full;
    logic                      len_max;
    logic [lzw_pkg::CNT_W-1:0] eff_limit;

    // Status terms shared by the sequencer
    assign slot_free = !out_valid_reg || !out_stall;
    assign used      = {1'b0, code_reg} < entry_count_reg;
    assign eff_limit = (code_limit_reg > lzw_pkg::CNT_W'(lzw_pkg::TABLE_DEPTH))
                     ? lzw_pkg::CNT_W'(lzw_pkg::TABLE_DEPTH) : code_limit_reg;
    assign full      = entry_count_reg >= eff_limit;
    assign len_max   = len_reg == lzw_pkg::LEN_W'(lzw_pkg::MAX_LEN);

    assign in_stall      = state_reg != lzw_pkg::S_IDLE;
    assign out_valid     = out_valid_reg;
    assign assigned_code = out_assigned_reg;
    assign out_byte      = out_byte_reg;
    assign last          = out_last_reg;
    assign status        = out_status_reg;

    // Table and stack memories
    lzw_ram #(
        .WIDTH (lzw_pkg::BYTE_W),
        .DEPTH (lzw_pkg::TABLE_DEPTH)
    ) u_suffix_ram (
        .clk   (clk),
        .we    (suf_we),
        .waddr (suf_waddr),
        .wdata (suf_wdata),
        .raddr (cur_next),
        .rdata (suf_rdata)
    );

    lzw_ram #(
        .WIDTH (lzw_pkg::PRE_W),
        .DEPTH (lzw_pkg::TABLE_DEPTH)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (pre_we),
        .waddr (entry_count_reg[lzw_pkg::CODE_W-1:0]),
        .wdata (pre_wdata),
        .raddr (cur_next),
        .rdata (pre_rdata)
    );

    lzw_ram #(
        .WIDTH (lzw_pkg::BYTE_W),
        .DEPTH (lzw_pkg::MAX_LEN)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (len_reg[lzw_pkg::SP_W-1:0]),
        .wdata (suf_rdata),
        .raddr (pos_next),
        .rdata (stk_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzw_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lzw_pkg::S_DECODE;
                end
            end
            lzw_pkg::S_DECODE:
            begin
                if (func_reg == lzw_pkg::FUNC_READ)
                begin
                    if (used)
                    begin
                        state_next = lzw_pkg::S_WALK;
                    end
                    else if (slot_free)
                    begin
                        state_next = lzw_pkg::S_IDLE;
                    end
                end
                else if (func_reg > lzw_pkg::FUNC_READ || slot_free)
                begin
                    // undefined codes drop without a result
                    state_next = lzw_pkg::S_IDLE;
                end
            end
            lzw_pkg::S_WALK:
            begin
                if (len_max)
                begin
                    state_next = lzw_pkg::S_LONG;
                end
                else if (!pre_rdata[lzw_pkg::CODE_W])
                begin
                    state_next = lzw_pkg::S_SETUP;
                end
            end
            lzw_pkg::S_LONG:
            begin
                if (slot_free)
                begin
                    state_next = lzw_pkg::S_IDLE;
                end
            end
            lzw_pkg::S_SETUP:
            begin
                state_next = lzw_pkg::S_EMIT;
            end
            lzw_pkg::S_EMIT:
            begin
                if (slot_free && pos_reg == '0)
                begin
                    state_next = lzw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lzw_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control: RAM writes, counters, result
    always_comb
    begin
        entry_count_next = entry_count_reg;
        cur_next         = cur_reg;
        len_next         = len_reg;
        pos_next         = pos_reg;
        suf_we           = 1'b0;
        suf_waddr        = entry_count_reg[lzw_pkg::CODE_W-1:0];
        suf_wdata        = value_reg;
        pre_we           = 1'b0;
        pre_wdata        = '0;
        stk_we           = 1'b0;
        emit             = 1'b0;
        e_assigned       = '0;
        e_byte           = '0;
        e_last           = 1'b1;
        e_status         = lzw_pkg::ST_OK;

        unique case (state_reg)
            lzw_pkg::S_IDLE:
            begin
                len_next = '0;
            end
            lzw_pkg::S_DECODE:
            begin
                cur_next = code_reg;
                len_next = '0;
                unique case (func_reg)
                    lzw_pkg::FUNC_CLEAR:
                    begin
                        if (slot_free)
                        begin
                            emit             = 1'b1;
                            entry_count_next = '0;
                        end
                    end
                    lzw_pkg::FUNC_ROOT:
                    begin
                        if (slot_free)
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                e_status = lzw_pkg::ST_FULL;
                            end
                            else
                            begin
                                suf_we           = 1'b1;
                                pre_we           = 1'b1;
                                e_assigned       = entry_count_reg[lzw_pkg::CODE_W-1:0];
                                entry_count_next = entry_count_reg + 1'b1;
                            end
                        end
                    end
                    lzw_pkg::FUNC_EXTEND:
                    begin
                        if (slot_free)
                        begin
                            emit = 1'b1;
                            if (!used)
                            begin
                                e_status = lzw_pkg::ST_UNUSED;
                            end
                            else if (full)
                            begin
                                e_status = lzw_pkg::ST_FULL;
                            end
                            else
                            begin
                                suf_we           = 1'b1;
                                suf_wdata        = '0;
                                pre_we           = 1'b1;
                                pre_wdata        = {1'b1, code_reg};
                                e_assigned       = entry_count_reg[lzw_pkg::CODE_W-1:0];
                                entry_count_next = entry_count_reg + 1'b1;
                            end
                        end
                    end
                    lzw_pkg::FUNC_SET:
                    begin
                        if (slot_free)
                        begin
                            emit = 1'b1;
                            if (!used)
                            begin
                                e_status = lzw_pkg::ST_UNUSED;
                            end
                            else
                            begin
                                suf_we    = 1'b1;
                                suf_waddr = code_reg;
                            end
                        end
                    end
                    lzw_pkg::FUNC_READ:
                    begin
                        if (!used && slot_free)
                        begin
                            emit     = 1'b1;
                            e_status = lzw_pkg::ST_UNUSED;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            lzw_pkg::S_WALK:
            begin
                // one link per cycle: push suffix, follow prefix
                if (!len_max)
                begin
                    stk_we   = 1'b1;
                    len_next = len_reg + 1'b1;
                    if (pre_rdata[lzw_pkg::CODE_W])
                    begin
                        cur_next = pre_rdata[lzw_pkg::CODE_W-1:0];
                    end
                end
            end
            lzw_pkg::S_LONG:
            begin
                if (slot_free)
                begin
                    emit     = 1'b1;
                    e_status = lzw_pkg::ST_LONG;
                end
            end
            lzw_pkg::S_SETUP:
            begin
                // top of stack holds the first byte of the string
                pos_next = lzw_pkg::SP_W'(len_reg - 1'b1);
            end
            lzw_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    emit   = 1'b1;
                    e_byte = stk_rdata;
                    e_last = pos_reg == '0;
                    if (pos_reg != '0)
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // output register load
        out_valid_next    = out_valid_reg && out_stall;
        out_assigned_next = out_assigned_reg;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        out_status_next   = out_status_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_assigned_next = e_assigned;
            out_byte_next     = e_byte;
            out_last_next     = e_last;
            out_status_next   = e_status;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lzw_pkg::S_IDLE;
            entry_count_reg <= '0;
            code_limit_reg  <= lzw_pkg::CODE_LIMIT_RESET;
            cur_reg         <= '0;
            len_reg         <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            cur_reg         <= cur_next;
            len_reg         <= len_next;
            pos_reg         <= pos_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write_en)
            begin
                code_limit_reg <= cfg_write_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg  <= func;
            code_reg  <= code;
            value_reg <= value;
        end
        out_assigned_reg <= out_assigned_next;
        out_byte_reg     <= out_byte_next;
        out_last_reg     <= out_last_next;
        out_status_reg   <= out_status_next;
    end

    // Checks
    `LZW_ASSERT_NXT(a_accept_decode, clk, rst_n, in_valid && !in_stall, state_reg == lzw_pkg::S_DECODE)
    `LZW_ASSERT_IMP(a_mid_string, clk, rst_n, out_valid_reg && !out_last_reg, state_reg == lzw_pkg::S_EMIT)
    `LZW_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, entry_count_reg <= lzw_pkg::CNT_W'(lzw_pkg::TABLE_DEPTH))
    `LZW_ASSERT_IMP(a_len_range, clk, rst_n, 1'b1, len_reg <= lzw_pkg::LEN_W'(lzw_pkg::MAX_LEN))

endmodule
